// File: rtl/vvp_pkg.sv
// Shared types and constants for the vertex view projection block.
// Used by the channel interfaces and by the top level; depends on nothing.

package vvp_pkg;

    // Field widths of the vertex, pixel and register formats.
    localparam int COORD_W    = 32;
    localparam int ANGLE_W    = 16;
    localparam int FOCAL_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Fraction bits dropped after each Q16.16 x Q2.14 rotation product.
    localparam int ROT_FRAC = 14;

    // A scaled term of 2^TERM_SAT_BITS or more always saturates the coordinate.
    localparam int TERM_SAT_BITS = 34;

    // Slice width used to split the wide scaling product into partial products.
    localparam int CHUNK_W = 17;

    // Width of the perspective quotient (|r| * 2^16 / |w|).
    localparam int QUOT_W = 55;
    // Width of the depth magnitude.
    localparam int DEPTH_W = 40;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic [FOCAL_W-1:0]        focal_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_POS_X    = 3'd0,
        REG_CAM_POS_Y    = 3'd1,
        REG_CAM_POS_Z    = 3'd2,
        REG_YAW_COSINE   = 3'd3,
        REG_YAW_SINE     = 3'd4,
        REG_PITCH_COSINE = 3'd5,
        REG_PITCH_SINE   = 3'd6,
        REG_FOCAL_SCALE  = 3'd7
    } cfg_reg_t;

    // Register values after reset.
    localparam coord_t CAM_POS_X_RST    = 32'sd327680;
    localparam coord_t CAM_POS_Y_RST    = 32'sd327680;
    localparam coord_t CAM_POS_Z_RST    = -32'sd327680;
    localparam angle_t YAW_COSINE_RST   = 16'sd11988;
    localparam angle_t YAW_SINE_RST     = 16'sd11168;
    localparam angle_t PITCH_COSINE_RST = 16'sd13676;
    localparam angle_t PITCH_SINE_RST   = 16'sd9023;
    localparam focal_t FOCAL_SCALE_RST  = 16'd6635;

endpackage

// File: rtl/vvp_if.sv
// Valid/ready channel interfaces for vertices in and pixels out.
// Depends on vvp_pkg for the field types.

// Vertex channel: one model vertex per transaction.
interface vvp_vertex_if import vvp_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t vertex_z;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    output ready);
endinterface

// Pixel channel: one projected point per transaction.
interface vvp_pixel_if import vvp_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t screen_x;
    coord_t screen_y;
    logic   in_screen;
    logic   zero_depth;

    modport source (output valid, output screen_x, output screen_y, output in_screen,
                    output zero_depth, input ready);
    modport sink   (input valid, input screen_x, input screen_y, input in_screen,
                    input zero_depth, output ready);
endinterface

// File: rtl/vvp_div.sv
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// Standalone; used by vertex_view_projection for the depth division.

module vvp_div #(
    parameter int NUM_W  = 55,
    parameter int DEN_W  = 40,
    parameter int SIDE_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  in_rem,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quot,
    output logic [SIDE_W-1:0] out_side
);

    // Stage registers; the dividend bits are shifted out of quot as quotient
    // bits are shifted in.
    logic              valid_reg [NUM_W];
    logic [DEN_W-1:0]  rem_reg   [NUM_W];
    logic [NUM_W-1:0]  quot_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg  [NUM_W];

    logic              valid_src [NUM_W];
    logic [DEN_W-1:0]  rem_src   [NUM_W];
    logic [NUM_W-1:0]  quot_src  [NUM_W];
    logic [DEN_W-1:0]  den_src   [NUM_W];
    logic [SIDE_W-1:0] side_src  [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [NUM_W-1:0] quot_next;

        // Stage input comes from the ports or from the previous stage.
        if (i == 0) begin : g_first
            assign valid_src[i] = in_valid;
            assign rem_src[i]   = in_rem;
            assign quot_src[i]  = in_num;
            assign den_src[i]   = in_den;
            assign side_src[i]  = in_side;
        end
        else begin : g_next
            assign valid_src[i] = valid_reg[i-1];
            assign rem_src[i]   = rem_reg[i-1];
            assign quot_src[i]  = quot_reg[i-1];
            assign den_src[i]   = den_reg[i-1];
            assign side_src[i]  = side_reg[i-1];
        end

        // One trial subtraction per stage.
        assign trial     = {rem_src[i], quot_src[i][NUM_W-1]};
        assign ge        = trial >= {1'b0, den_src[i]};
        assign diff      = trial - {1'b0, den_src[i]};
        assign rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign quot_next = {quot_src[i][NUM_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_src[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                quot_reg[i] <= quot_next;
                den_reg[i]  <= den_src[i];
                side_reg[i] <= side_src[i];
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quot  = quot_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

// File: rtl/vertex_view_projection.sv
// Perspective projection of model vertices through a yaw/pitch camera.
// Depends on vvp_pkg, vvp_if (channel interfaces) and vvp_div.

// One vertex enters per clock cycle unless the output stalls. In order, six
// stages form the camera offset and the two rotations, a 55-stage divider makes
// the perspective quotient, three stages clamp and multiply by the focal scale,
// three stages divide by the screen constant through a reciprocal multiply, and
// one stage saturates into the output register. The whole pipeline advances
// together and holds while an unaccepted result waits at the output. Registers
// should be written only while no vertex is in flight.
module vertex_view_projection import vvp_pkg::*; #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    vvp_vertex_if.sink            vtx,
    vvp_pixel_if.source           pix
);

    // Position of the lowest set bit of a constant.
    function automatic int low_zeros(longint unsigned v);
        int n;
        n = 0;
        for (int i = 63; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = i;
            end
        end
        return n;
    endfunction

    // Scale constants: term = |t| * focal * KC / D for each axis.
    localparam longint unsigned KC_X = longint'(SCREEN_WIDTH) * longint'(SCREEN_WIDTH);
    localparam longint unsigned D_X  = 2 * longint'(SCREEN_HEIGHT) * 4096;
    localparam longint unsigned KC_Y = longint'(SCREEN_HEIGHT);
    localparam longint unsigned D_Y  = 8192;
    localparam longint unsigned SAT_X = (64'd1 << TERM_SAT_BITS) * D_X;
    localparam longint unsigned SAT_Y = (64'd1 << TERM_SAT_BITS) * D_Y;
    localparam int LB_X = $clog2((SAT_X + KC_X - 1) / KC_X);
    localparam int LB_Y = $clog2((SAT_Y + KC_Y - 1) / KC_Y);
    localparam int LB   = (LB_X > LB_Y) ? LB_X : LB_Y;
    localparam int MB   = LB + 1;
    localparam longint unsigned KC_MAX = (KC_X > KC_Y) ? KC_X : KC_Y;
    localparam int KW   = FOCAL_W + $clog2(KC_MAX + 1);
    localparam int NCH  = (MB + CHUNK_W - 1) / CHUNK_W;
    localparam int PADW = NCH * CHUNK_W;
    localparam int PW   = PADW + KW;
    localparam int CMPW = (PW > 64) ? PW : 64;
    localparam int RW   = 37;

    localparam logic [RW-1:0] OFF_X   = RW'(SCREEN_WIDTH * 32768);
    localparam logic [RW-1:0] OFF_Y   = RW'(SCREEN_HEIGHT * 32768);
    localparam logic [31:0]   LIM_X   = 32'(SCREEN_WIDTH * 65536);
    localparam logic [31:0]   LIM_Y   = 32'(SCREEN_HEIGHT * 65536);
    localparam logic [RW-1:0] TERM_CAP = RW'(64'd1 << TERM_SAT_BITS);

    // Configuration registers.
    coord_t cam_x_reg, cam_y_reg, cam_z_reg;
    angle_t yaw_c_reg, yaw_s_reg, pitch_c_reg, pitch_s_reg;
    focal_t focal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg   <= CAM_POS_X_RST;
            cam_y_reg   <= CAM_POS_Y_RST;
            cam_z_reg   <= CAM_POS_Z_RST;
            yaw_c_reg   <= YAW_COSINE_RST;
            yaw_s_reg   <= YAW_SINE_RST;
            pitch_c_reg <= PITCH_COSINE_RST;
            pitch_s_reg <= PITCH_SINE_RST;
            focal_reg   <= FOCAL_SCALE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAM_POS_X:    cam_x_reg   <= cfg_data;
                REG_CAM_POS_Y:    cam_y_reg   <= cfg_data;
                REG_CAM_POS_Z:    cam_z_reg   <= cfg_data;
                REG_YAW_COSINE:   yaw_c_reg   <= cfg_data[ANGLE_W-1:0];
                REG_YAW_SINE:     yaw_s_reg   <= cfg_data[ANGLE_W-1:0];
                REG_PITCH_COSINE: pitch_c_reg <= cfg_data[ANGLE_W-1:0];
                REG_PITCH_SINE:   pitch_s_reg <= cfg_data[ANGLE_W-1:0];
                REG_FOCAL_SCALE:  focal_reg   <= cfg_data[FOCAL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Global pipeline advance: move when the output register is free or taken.
    logic out_valid_reg;
    logic en;
    assign en        = !out_valid_reg || pix.ready;
    assign vtx.ready = en;

    // Valid bits of the front stages.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s6_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= vtx.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Stage 1: offset from the camera, z negated.
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    // Stage 2: yaw products.
    logic signed [48:0] pxc_reg, pzs_reg, pxs_reg, pzc_reg;
    logic signed [32:0] dy2_reg;
    // Stage 3: yawed coordinates.
    logic signed [35:0] rx_reg, rz1_reg;
    logic signed [32:0] dy3_reg;
    logic signed [49:0] yaw_x_sum, yaw_z_sum;
    // Stage 4: pitch products.
    logic signed [48:0] pyc_reg, pys_reg;
    logic signed [51:0] pzs2_reg, pzc2_reg;
    logic signed [35:0] rx4_reg;
    // Stage 5: pitched coordinates.
    logic signed [38:0] ry_reg, rz2_reg;
    logic signed [35:0] rx5_reg;
    logic signed [52:0] pit_y_sum, pit_z_sum;
    // Stage 6: divider operands.
    logic signed [DEPTH_W-1:0] w_val;
    logic [35:0]          rx_mag;
    logic [38:0]          ry_mag;
    logic [DEPTH_W-1:0]   w_mag;
    logic [QUOT_W-1:0]    num_next [2];
    logic [QUOT_W-1:0]    num_reg  [2];
    logic                 sign_next [2];
    logic                 sign_reg  [2];
    logic [DEPTH_W-1:0]   den_next, den_reg;
    logic                 zero_next, zero_reg;

    assign yaw_x_sum = 50'(pxc_reg) - 50'(pzs_reg);
    assign yaw_z_sum = 50'(pxs_reg) + 50'(pzc_reg);
    assign pit_y_sum = 53'(pyc_reg) - 53'(pzs2_reg);
    assign pit_z_sum = 53'(pys_reg) + 53'(pzc2_reg);

    always_comb
    begin
        w_val        = -DEPTH_W'(rz2_reg);
        rx_mag       = rx5_reg[35] ? 36'(-rx5_reg) : 36'(rx5_reg);
        ry_mag       = ry_reg[38] ? 39'(-ry_reg) : 39'(ry_reg);
        w_mag        = w_val[DEPTH_W-1] ? DEPTH_W'(-w_val) : DEPTH_W'(w_val);
        zero_next    = (rz2_reg == '0);
        den_next     = zero_next ? DEPTH_W'(1) : w_mag;
        num_next[0]  = QUOT_W'({rx_mag, 16'b0});
        num_next[1]  = QUOT_W'({ry_mag, 16'b0});
        sign_next[0] = rx5_reg[35] ^ w_val[DEPTH_W-1];
        sign_next[1] = ry_reg[38] ^ w_val[DEPTH_W-1];
    end

    // Front datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg   <= 33'(vtx.vertex_x) - 33'(cam_x_reg);
            dy_reg   <= 33'(vtx.vertex_y) - 33'(cam_y_reg);
            dz_reg   <= 33'(cam_z_reg) - 33'(vtx.vertex_z);

            pxc_reg  <= 49'(dx_reg) * 49'(yaw_c_reg);
            pzs_reg  <= 49'(dz_reg) * 49'(yaw_s_reg);
            pxs_reg  <= 49'(dx_reg) * 49'(yaw_s_reg);
            pzc_reg  <= 49'(dz_reg) * 49'(yaw_c_reg);
            dy2_reg  <= dy_reg;

            rx_reg   <= yaw_x_sum[49:ROT_FRAC];
            rz1_reg  <= yaw_z_sum[49:ROT_FRAC];
            dy3_reg  <= dy2_reg;

            pyc_reg  <= 49'(dy3_reg) * 49'(pitch_c_reg);
            pys_reg  <= 49'(dy3_reg) * 49'(pitch_s_reg);
            pzs2_reg <= 52'(rz1_reg) * 52'(pitch_s_reg);
            pzc2_reg <= 52'(rz1_reg) * 52'(pitch_c_reg);
            rx4_reg  <= rx_reg;

            ry_reg   <= pit_y_sum[52:ROT_FRAC];
            rz2_reg  <= pit_z_sum[52:ROT_FRAC];
            rx5_reg  <= rx4_reg;

            num_reg[0]  <= num_next[0];
            num_reg[1]  <= num_next[1];
            sign_reg[0] <= sign_next[0];
            sign_reg[1] <= sign_next[1];
            den_reg     <= den_next;
            zero_reg    <= zero_next;
        end
    end

    // Per-axis back end: divide by depth, scale, divide by the screen constant.
    logic        fin_valid [2];
    logic        fin_zero  [2];
    logic [31:0] fin_coord [2];

    for (genvar a = 0; a < 2; a++) begin : g_axis
        localparam longint unsigned KC_A = (a == 0) ? KC_X : KC_Y;
        localparam longint unsigned D_A  = (a == 0) ? D_X : D_Y;
        localparam longint unsigned SAT_A = (a == 0) ? SAT_X : SAT_Y;

        // Reciprocal of the odd part of D; exact for every unsaturated product.
        localparam int              TZ_A = low_zeros(D_A);
        localparam longint unsigned DO_A = D_A >> TZ_A;
        localparam int              DB_A = $clog2(DO_A);
        localparam int              NB_A = $clog2(SAT_A >> TZ_A);
        localparam int              S_A  = NB_A + DB_A;
        localparam longint unsigned M_A  = ((64'd1 << S_A) + DO_A - 1) / DO_A;
        localparam int              MW_A = $clog2(M_A + 1);
        localparam int              NCA  = (NB_A + CHUNK_W - 1) / CHUNK_W;
        localparam int              NCM  = (MW_A + CHUNK_W - 1) / CHUNK_W;
        localparam int              NPW  = NCA * CHUNK_W;
        localparam int              NMW  = NCM * CHUNK_W;
        localparam int              ROWW = NMW + CHUNK_W;
        localparam int              QPW  = NPW + NMW;
        localparam logic [NMW-1:0]  M_PAD = NMW'(M_A);

        logic              mv;
        logic [QUOT_W-1:0] mq;
        logic [1:0]        ms;

        vvp_div #(
            .NUM_W  (QUOT_W),
            .DEN_W  (DEPTH_W),
            .SIDE_W (2)
        ) u_depth_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (s6_valid_reg),
            .in_rem    ('0),
            .in_num    (num_reg[a]),
            .in_den    (den_reg),
            .in_side   ({zero_reg, sign_reg[a]}),
            .out_valid (mv),
            .out_quot  (mq),
            .out_side  (ms)
        );

        // Focal scale times the axis constant; follows the register.
        logic [KW-1:0] k_reg;
        always_ff @(posedge clk)
        begin
            k_reg <= KW'(focal_reg) * KW'(KC_A);
        end

        logic               v7_reg, v8_reg, v9_reg;
        logic [1:0]         side7_reg, side8_reg, side9_reg;
        logic [MB-1:0]      magc_next, magc_reg;
        logic [PADW-1:0]    magp;
        logic [CHUNK_W+KW-1:0] pp_reg [NCH];
        logic [PW-1:0]      prod_next, prod_reg;
        logic               sat_next, sat_reg;

        // A quotient beyond 2^LB saturates the coordinate for any nonzero focal.
        assign magc_next = (mq >= QUOT_W'(64'd1 << LB)) ? MB'(64'd1 << LB) : mq[MB-1:0];
        assign magp      = PADW'(magc_reg);

        // Sum of the shifted partial products.
        always_comb
        begin
            prod_next = '0;
            for (int j = 0; j < NCH; j++)
            begin
                prod_next = prod_next + (PW'(pp_reg[j]) << (j * CHUNK_W));
            end
            sat_next = CMPW'(prod_next) >= CMPW'(SAT_A);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v7_reg <= 1'b0;
                v8_reg <= 1'b0;
                v9_reg <= 1'b0;
            end
            else if (en)
            begin
                v7_reg <= mv;
                v8_reg <= v7_reg;
                v9_reg <= v8_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                magc_reg  <= magc_next;
                side7_reg <= ms;
                for (int j = 0; j < NCH; j++)
                begin
                    pp_reg[j] <= (CHUNK_W+KW)'(magp[j*CHUNK_W +: CHUNK_W])
                               * (CHUNK_W+KW)'(k_reg);
                end
                side8_reg <= side7_reg;
                prod_reg  <= prod_next;
                sat_reg   <= sat_next;
                side9_reg <= side8_reg;
            end
        end

        // Screen constant division: drop the power-of-two factor, multiply by
        // the reciprocal in 17-bit pieces, sum by rows, then sum the rows.
        logic [NPW-1:0]           pq;
        logic [2*CHUNK_W-1:0]     rp_reg   [NCA][NCM];
        logic [ROWW-1:0]          row_next [NCA];
        logic [ROWW-1:0]          row_reg  [NCA];
        logic [QPW-1:0]           full_next;
        logic [TERM_SAT_BITS-1:0] q_next, q_reg;
        logic                     v10_reg, v11_reg, v12_reg;
        logic [2:0]               side10_reg, side11_reg, side12_reg;

        assign pq = NPW'(prod_reg >> TZ_A);

        always_comb
        begin
            for (int i = 0; i < NCA; i++)
            begin
                row_next[i] = '0;
                for (int j = 0; j < NCM; j++)
                begin
                    row_next[i] = row_next[i] + (ROWW'(rp_reg[i][j]) << (j * CHUNK_W));
                end
            end
            full_next = '0;
            for (int i = 0; i < NCA; i++)
            begin
                full_next = full_next + (QPW'(row_reg[i]) << (i * CHUNK_W));
            end
            q_next = TERM_SAT_BITS'(full_next >> S_A);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v10_reg <= 1'b0;
                v11_reg <= 1'b0;
                v12_reg <= 1'b0;
            end
            else if (en)
            begin
                v10_reg <= v9_reg;
                v11_reg <= v10_reg;
                v12_reg <= v11_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < NCA; i++)
                begin
                    for (int j = 0; j < NCM; j++)
                    begin
                        rp_reg[i][j] <= (2*CHUNK_W)'(pq[i*CHUNK_W +: CHUNK_W])
                                      * (2*CHUNK_W)'(M_PAD[j*CHUNK_W +: CHUNK_W]);
                    end
                end
                side10_reg <= {side9_reg, sat_reg};
                for (int i = 0; i < NCA; i++)
                begin
                    row_reg[i] <= row_next[i];
                end
                side11_reg <= side10_reg;
                q_reg      <= q_next;
                side12_reg <= side11_reg;
            end
        end

        logic                     cv;
        logic [TERM_SAT_BITS-1:0] cq;
        logic [2:0]               cs;

        assign cv = v12_reg;
        assign cq = q_reg;
        assign cs = side12_reg;

        // Apply the term to the screen center and clamp to 32 bits.
        logic [RW-1:0] term;
        logic [RW-1:0] sterm;
        logic [RW-1:0] raw;

        always_comb
        begin
            term  = cs[0] ? TERM_CAP : RW'(cq);
            sterm = cs[1] ? -term : term;
            if (a == 0)
            begin
                raw = OFF_X + sterm;
            end
            else
            begin
                raw = OFF_Y - sterm;
            end
            if (!raw[RW-1] && raw[RW-2:31] != '0)
            begin
                fin_coord[a] = 32'h7FFF_FFFF;
            end
            else if (raw[RW-1] && raw[RW-2:31] != '1)
            begin
                fin_coord[a] = 32'h8000_0000;
            end
            else
            begin
                fin_coord[a] = raw[31:0];
            end
        end

        assign fin_valid[a] = cv;
        assign fin_zero[a]  = cs[2];
    end

    // Output register.
    logic        zero_out;
    logic [31:0] sx_next, sy_next;
    logic        vis_next;
    coord_t      sx_reg, sy_reg;
    logic        vis_reg, zero_out_reg;

    always_comb
    begin
        zero_out = fin_zero[0] | fin_zero[1];
        sx_next  = zero_out ? 32'h7FFF_FFFF : fin_coord[0];
        sy_next  = zero_out ? 32'h7FFF_FFFF : fin_coord[1];
        vis_next = !zero_out && !sx_next[31] && (sx_next < LIM_X)
                   && !sy_next[31] && (sy_next < LIM_Y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin_valid[0] & fin_valid[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            vis_reg      <= vis_next;
            zero_out_reg <= zero_out;
        end
    end

    assign pix.valid      = out_valid_reg;
    assign pix.screen_x   = sx_reg;
    assign pix.screen_y   = sy_reg;
    assign pix.in_screen  = vis_reg;
    assign pix.zero_depth = zero_out_reg;

    // A vertex at zero depth is reported off screen with both coordinates pinned.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.zero_depth |-> !pix.in_screen
            && pix.screen_x == 32'h7FFF_FFFF && pix.screen_y == 32'h7FFF_FFFF)
        else $error("zero depth result is not pinned off screen");

    // A visible pixel has non-negative coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.in_screen |-> !pix.screen_x[31] && !pix.screen_y[31])
        else $error("visible pixel with negative coordinate");

    // An accepted vertex occupies the first stage on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        vtx.valid && vtx.ready |=> s1_valid_reg)
        else $error("accepted vertex lost at pipeline entry");

endmodule
